>>> rtl/pcd_pkg.sv
// Shared types and constants for the page cache LRU directory.
package pcd_pkg;

    localparam int PAGE_W   = 32;
    localparam int OFFSET_W = 48;
    localparam int COUNT_W  = 64;
    localparam int SHIFT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [PAGE_W-1:0]  MAX_PAGES           = 32'hFFFF_FFFF;
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET    = 5'd12;
    localparam logic [PAGE_W-1:0]  INITIAL_PAGES_RESET = 32'd1;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

    localparam logic REG_PAGE_SHIFT    = 1'b0;
    localparam logic REG_INITIAL_PAGES = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] page_shift;
        logic               load_pages;
        logic [PAGE_W-1:0]  load_value;
    } cfg_t;

endpackage

>>> rtl/pcd_req_if.sv
// Request channel: operation and page number.
interface pcd_req_if
    import pcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [PAGE_W-1:0] page_no;

    modport source (output valid, output op, output page_no, input ready);
    modport sink   (input valid, input op, input page_no, output ready);
endinterface

>>> rtl/pcd_rsp_if.sv
// Response channel: status, hit flag, offset, allocated page and counters.
interface pcd_rsp_if
    import pcd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [OFFSET_W-1:0] byte_offset;
    logic [PAGE_W-1:0]   alloc_page;
    logic [COUNT_W-1:0]  hit_count;
    logic [COUNT_W-1:0]  miss_count;

    modport source (output valid, output status, output hit, output byte_offset,
                    output alloc_page, output hit_count, output miss_count, input ready);
    modport sink   (input valid, input status, input hit, input byte_offset,
                    input alloc_page, input hit_count, input miss_count, output ready);
endinterface

>>> rtl/pcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> rtl/pcd_cfg.sv
// APB configuration registers: page shift and initial page count.
module pcd_cfg
    import pcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);
    logic [SHIFT_W-1:0] page_shift_reg;
    logic [PAGE_W-1:0]  initial_pages_reg;
    logic               wr_en;
    logic               reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg    <= PAGE_SHIFT_RESET;
            initial_pages_reg <= INITIAL_PAGES_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PAGE_SHIFT:    page_shift_reg    <= pwdata[SHIFT_W-1:0];
                REG_INITIAL_PAGES: initial_pages_reg <= pwdata;
                default:           page_shift_reg    <= page_shift_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PAGE_SHIFT:    prdata = {{(32-SHIFT_W){1'b0}}, page_shift_reg};
            REG_INITIAL_PAGES: prdata = initial_pages_reg;
            default:           prdata = '0;
        endcase
    end

    assign cfg.page_shift = page_shift_reg;
    assign cfg.load_pages = wr_en & (reg_idx == REG_INITIAL_PAGES);
    assign cfg.load_value = pwdata;
endmodule

>>> rtl/pcd_core.sv
// Sequencer: scans the directory RAM with one compare unit, then rewrites ranks.
module pcd_core
    import pcd_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cfg_t                                   cfg,
    pcd_req_if.sink                                req,
    pcd_rsp_if.source                              rsp,
    output logic                                   ram_we,
    output logic [$clog2(ENTRIES)-1:0]             ram_waddr,
    output logic [PAGE_W+$clog2(ENTRIES)-1:0]      ram_wdata,
    output logic                                   ram_re,
    output logic [$clog2(ENTRIES)-1:0]             ram_raddr,
    input  logic [PAGE_W+$clog2(ENTRIES)-1:0]      ram_rdata
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    state_t state_reg, state_next;

    logic [PAGE_W-1:0]   pages_reg, pages_next;
    logic [COUNT_W-1:0]  hits_reg, hits_next;
    logic [COUNT_W-1:0]  misses_reg, misses_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       rd_addr_reg, rd_addr_next;
    logic [CW-1:0]       limit_reg, limit_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [AW-1:0]       dat_idx_reg, dat_idx_next;

    logic                found_reg, found_next;
    logic [AW-1:0]       found_idx_reg, found_idx_next;
    logic [AW-1:0]       found_age_reg, found_age_next;
    logic                vict_any_reg, vict_any_next;
    logic [AW-1:0]       vict_idx_reg, vict_idx_next;
    logic [AW-1:0]       vict_age_reg, vict_age_next;

    logic [AW-1:0]       target_reg, target_next;
    logic [AW-1:0]       old_age_reg, old_age_next;
    logic                age_all_reg, age_all_next;

    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_hit_reg, res_hit_next;
    logic [OFFSET_W-1:0] res_offset_reg, res_offset_next;
    logic [PAGE_W-1:0]   res_newp_reg, res_newp_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_load;

    logic [OFFSET_W-1:0] offset_calc;
    logic [PAGE_W-1:0]   dat_page;
    logic [AW-1:0]       dat_age;
    logic                issue;

    assign offset_calc = {{(OFFSET_W-PAGE_W){1'b0}}, req.page_no} << cfg.page_shift;
    assign dat_page    = ram_rdata[PAGE_W+AW-1:AW];
    assign dat_age     = ram_rdata[AW-1:0];
    assign req.ready   = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pages_reg     <= INITIAL_PAGES_RESET;
            hits_reg      <= '0;
            misses_reg    <= '0;
            fill_reg      <= '0;
            rd_addr_reg   <= '0;
            limit_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            vict_any_reg  <= 1'b0;
            age_all_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pages_reg     <= pages_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            fill_reg      <= fill_next;
            rd_addr_reg   <= rd_addr_next;
            limit_reg     <= limit_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            vict_any_reg  <= vict_any_next;
            age_all_reg   <= age_all_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dat_idx_reg    <= dat_idx_next;
        found_idx_reg  <= found_idx_next;
        found_age_reg  <= found_age_next;
        vict_idx_reg   <= vict_idx_next;
        vict_age_reg   <= vict_age_next;
        target_reg     <= target_next;
        old_age_reg    <= old_age_next;
        page_reg       <= page_next;
        res_status_reg <= res_status_next;
        res_hit_reg    <= res_hit_next;
        res_offset_reg <= res_offset_next;
        res_newp_reg   <= res_newp_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp.status      <= res_status_reg;
            rsp.hit         <= res_hit_reg;
            rsp.byte_offset <= res_offset_reg;
            rsp.alloc_page  <= res_newp_reg;
            rsp.hit_count   <= hits_reg;
            rsp.miss_count  <= misses_reg;
        end
    end

    assign rsp.valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        pages_next      = pages_reg;
        hits_next       = hits_reg;
        misses_next     = misses_reg;
        fill_next       = fill_reg;
        rd_addr_next    = rd_addr_reg;
        limit_next      = limit_reg;
        rd_vld_next     = 1'b0;
        dat_idx_next    = dat_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_age_next  = found_age_reg;
        vict_any_next   = vict_any_reg;
        vict_idx_next   = vict_idx_reg;
        vict_age_next   = vict_age_reg;
        target_next     = target_reg;
        old_age_next    = old_age_reg;
        age_all_next    = age_all_reg;
        page_next       = page_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        res_offset_next = res_offset_reg;
        res_newp_next   = res_newp_reg;
        out_load        = 1'b0;
        out_valid_next  = out_valid_reg & ~rsp.ready;
        issue           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = dat_idx_reg;
        ram_wdata       = ram_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    page_next       = req.page_no;
                    res_status_next = STATUS_OK;
                    res_hit_next    = 1'b0;
                    res_offset_next = '0;
                    res_newp_next   = '0;
                    if (req.op == OP_ALLOC)
                    begin
                        if (pages_reg == MAX_PAGES)
                        begin
                            res_status_next = STATUS_SAT;
                        end
                        else
                        begin
                            res_newp_next = pages_reg;
                            pages_next    = pages_reg + 32'd1;
                        end
                        state_next = ST_DONE;
                    end
                    else if (req.page_no >= pages_reg)
                    begin
                        res_status_next = STATUS_RANGE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        res_offset_next = offset_calc;
                        found_next      = 1'b0;
                        vict_any_next   = 1'b0;
                        rd_addr_next    = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_addr_reg < fill_reg)
                begin
                    issue        = 1'b1;
                    rd_vld_next  = 1'b1;
                    dat_idx_next = rd_addr_reg[AW-1:0];
                    rd_addr_next = rd_addr_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    if (!found_reg && (dat_page == page_reg))
                    begin
                        found_next     = 1'b1;
                        found_idx_next = dat_idx_reg;
                        found_age_next = dat_age;
                    end
                    if (!vict_any_reg || (dat_age > vict_age_reg))
                    begin
                        vict_any_next = 1'b1;
                        vict_idx_next = dat_idx_reg;
                        vict_age_next = dat_age;
                    end
                end
                if ((rd_addr_reg == fill_reg) && !rd_vld_reg)
                begin
                    rd_addr_next = '0;
                    limit_next   = fill_reg;
                    age_all_next = 1'b0;
                    if (found_reg)
                    begin
                        target_next  = found_idx_reg;
                        old_age_next = found_age_reg;
                    end
                    else if (fill_reg < CW'(ENTRIES))
                    begin
                        target_next  = fill_reg[AW-1:0];
                        old_age_next = '0;
                        age_all_next = 1'b1;
                        limit_next   = fill_reg + CW'(1);
                    end
                    else
                    begin
                        target_next  = vict_idx_reg;
                        old_age_next = vict_age_reg;
                    end
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                if (rd_addr_reg < limit_reg)
                begin
                    issue        = 1'b1;
                    rd_vld_next  = 1'b1;
                    dat_idx_next = rd_addr_reg[AW-1:0];
                    rd_addr_next = rd_addr_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    ram_we = 1'b1;
                    if (dat_idx_reg == target_reg)
                    begin
                        ram_wdata = {(found_reg ? dat_page : page_reg), {AW{1'b0}}};
                    end
                    else if (age_all_reg || (dat_age < old_age_reg))
                    begin
                        ram_wdata = {dat_page, dat_age + AW'(1)};
                    end
                end
                if ((rd_addr_reg == limit_reg) && !rd_vld_reg)
                begin
                    res_hit_next = found_reg;
                    if (found_reg)
                    begin
                        hits_next = hits_reg + 64'd1;
                    end
                    else
                    begin
                        misses_next = misses_reg + 64'd1;
                    end
                    if (age_all_reg)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg.load_pages)
        begin
            pages_next = (cfg.load_value == '0) ? 32'd1 : cfg.load_value;
        end
    end

    assign ram_re    = issue;
    assign ram_raddr = rd_addr_reg[AW-1:0];
endmodule

>>> rtl/page_cache_lru_directory.sv
// Top level of the page cache LRU directory: config port, sequencer and directory RAM.
//
//  Channel | Direction | Handshake          | Payload
//  req     | in        | valid/ready        | op, page_no
//  rsp     | out       | valid/ready        | status, hit, byte_offset, alloc_page,
//          |           |                    | hit_count, miss_count
//  apb     | in        | psel/penable/pready| paddr, pwdata, prdata
//
//  Alloc and out-of-range reads skip the directory RAM and go straight to the result stage.
//  In-range reads make two passes over the directory RAM, a match scan and a rank rewrite,
//  each over the N filled entries; when a free entry is filled, the rewrite covers it too.
//  Reset needs no clearing pass; a fill count marks which entries hold pages.
//  req.ready is low while a transaction is in progress or its result is waiting to load.
module page_cache_lru_directory
    import pcd_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    pcd_req_if.sink     req,
    pcd_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW     = $clog2(ENTRIES);
    localparam int WORD_W = PAGE_W + AW;

    cfg_t              cfg;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    pcd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcd_core #(
        .ENTRIES (ENTRIES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    pcd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_dir_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule
